### hdl/ted_pkg.sv
package ted_pkg;

    // curve store geometry, fixed by the 12-bit entry index and position fields
    localparam int CURVE_DEPTH = 4096;
    localparam int CIDX_W      = 12;
    localparam int LEN_W       = 13;
    localparam int DELAY_CFG_W = 10;
    localparam int ENTRY_W     = 17;
    localparam int GAIN_W      = 17;

    localparam logic [ENTRY_W-1:0] FULL_DUCK = 17'h10000;

    // defaults for the top level parameters
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_DELAY_DEPTH = 1024;

    // result buffer depth, power of two
    localparam int FIFO_DEPTH = 4;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // register index codes (word address bit 2)
    localparam logic REG_CURVE_LENGTH  = 1'b0;
    localparam logic REG_DELAY_SAMPLES = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    // per-lane control for the accept stage
    typedef struct packed {
        logic sample_we;
        logic fill_ok;
        logic bypass;
    } lane_ctl_t;

    // last playable curve entry for a raw length value
    function automatic logic [CIDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
        logic [CIDX_W-1:0] res;
        if (len == '0)
            res = '0;
        else if (len > LEN_W'(CURVE_DEPTH))
            res = CIDX_W'(CURVE_DEPTH - 1);
        else
            res = CIDX_W'(len - 13'd1);
        return res;
    endfunction

endpackage

### hdl/ted_lane.sv
module ted_lane #(
    parameter int SAMPLE_BITS = ted_pkg::DEF_SAMPLE_BITS,
    parameter int DELAY_DEPTH = ted_pkg::DEF_DELAY_DEPTH,
    parameter int DPTR_W      = 10
) (
    input  logic                          clk,
    input  ted_pkg::lane_ctl_t            ctl,
    input  logic [DPTR_W-1:0]             wr_addr,
    input  logic [DPTR_W-1:0]             rd_addr,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [ted_pkg::GAIN_W-1:0]    gain,
    output logic signed [SAMPLE_BITS-1:0] scaled
);

    localparam int PROD_W = SAMPLE_BITS + ted_pkg::GAIN_W + 1;

    logic [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];

    logic [SAMPLE_BITS-1:0]        mem_q_reg;
    logic [SAMPLE_BITS-1:0]        in_q_reg;
    logic                          fill_ok_reg;
    logic                          bypass_reg;
    logic signed [SAMPLE_BITS-1:0] sel_sample;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;

    // delay line: write at the head, read the tap
    always_ff @(posedge clk)
    begin
        if (ctl.sample_we)
        begin
            delay_mem[wr_addr] <= sample_in;
        end
        mem_q_reg <= delay_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        in_q_reg    <= sample_in;
        fill_ok_reg <= ctl.fill_ok;
        bypass_reg  <= ctl.bypass;
        prod_reg    <= prod_next;
    end

    // untouched slots read as zero
    always_comb
    begin
        if (bypass_reg)
            sel_sample = $signed(in_q_reg);
        else if (fill_ok_reg)
            sel_sample = $signed(mem_q_reg);
        else
            sel_sample = '0;
        prod_next = sel_sample * $signed({1'b0, gain});
    end

    // arithmetic shift by 16, floor rounding
    assign scaled = prod_reg[SAMPLE_BITS+15:16];

endmodule

### hdl/ted_curve.sv
module ted_curve (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_we,
    input  logic [ted_pkg::CIDX_W-1:0]        load_idx,
    input  logic [ted_pkg::ENTRY_W-1:0]       load_val,
    input  logic                              smp_acc,
    input  logic                              trigger,
    input  logic                              len_we,
    input  logic [ted_pkg::LEN_W-1:0]         len_val,
    output logic [ted_pkg::CIDX_W-1:0]        pos,
    output logic [ted_pkg::ENTRY_W-1:0]       entry_q,
    output logic                              busy
);

    logic [ted_pkg::ENTRY_W-1:0] curve_mem [ted_pkg::CURVE_DEPTH];

    logic                         clr_active_reg, clr_active_next;
    logic [ted_pkg::CIDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ted_pkg::CIDX_W-1:0]   play_pos_reg, play_pos_next;
    logic [ted_pkg::CIDX_W-1:0]   last_reg, last_next;
    logic [ted_pkg::CIDX_W-1:0]   start_pos;
    logic [ted_pkg::ENTRY_W-1:0]  clamped_val;
    logic                         mem_we;
    logic [ted_pkg::CIDX_W-1:0]   mem_addr;
    logic [ted_pkg::ENTRY_W-1:0]  mem_data;
    logic [ted_pkg::ENTRY_W-1:0]  entry_reg;

    always_comb
    begin
        clamped_val = (load_val > ted_pkg::FULL_DUCK) ? ted_pkg::FULL_DUCK : load_val;
        mem_we      = clr_active_reg | load_we;
        mem_addr    = clr_active_reg ? clr_addr_reg : load_idx;
        mem_data    = clr_active_reg ? ted_pkg::FULL_DUCK : clamped_val;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            curve_mem[mem_addr] <= mem_data;
        end
        entry_reg <= curve_mem[pos];
    end

    assign entry_q = entry_reg;
    assign busy    = clr_active_reg;

    // play position: restart on trigger, advance and hold at the last entry; a length write parks it there
    always_comb
    begin
        start_pos = trigger ? '0 : play_pos_reg;
        pos       = (start_pos > last_reg) ? last_reg : start_pos;
        last_next = last_reg;
        play_pos_next = play_pos_reg;
        if (len_we)
        begin
            last_next     = ted_pkg::last_index(len_val);
            play_pos_next = ted_pkg::last_index(len_val);
        end
        else if (smp_acc)
        begin
            play_pos_next = (pos < last_reg) ? pos + 1'b1 : pos;
        end
        clr_addr_next   = clr_addr_reg + 1'b1;
        clr_active_next = clr_active_reg &&
                          (clr_addr_reg != ted_pkg::CIDX_W'(ted_pkg::CURVE_DEPTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            play_pos_reg   <= ted_pkg::last_index(ted_pkg::LEN_RESET);
            last_reg       <= ted_pkg::last_index(ted_pkg::LEN_RESET);
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            play_pos_reg   <= play_pos_next;
            last_reg       <= last_next;
        end
    end

endmodule

### hdl/ted_merge.sv
module ted_merge #(
    parameter int SAMPLE_BITS = ted_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] left_res,
    input  logic signed [SAMPLE_BITS-1:0] right_res,
    input  logic [ted_pkg::CIDX_W-1:0]    pos_res,
    input  logic                          restart_res,
    input  logic [1:0]                    inflight,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [ted_pkg::CIDX_W-1:0]    curve_position,
    output logic                          restarted
);

    localparam int PTR_W = $clog2(ted_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ted_pkg::FIFO_DEPTH + 1);

    logic [SAMPLE_BITS-1:0]        left_q  [ted_pkg::FIFO_DEPTH];
    logic [SAMPLE_BITS-1:0]        right_q [ted_pkg::FIFO_DEPTH];
    logic [ted_pkg::CIDX_W-1:0]    pos_q   [ted_pkg::FIFO_DEPTH];
    logic                          rst_q   [ted_pkg::FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W:0]   committed;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);

    assign left_out       = $signed(left_q[rd_ptr_reg]);
    assign right_out      = $signed(right_q[rd_ptr_reg]);
    assign curve_position = pos_q[rd_ptr_reg];
    assign restarted      = rst_q[rd_ptr_reg];

    // room counts items still on their way through the lanes
    always_comb
    begin
        committed   = (CNT_W+1)'(count_reg) + (CNT_W+1)'(inflight);
        room        = committed < (CNT_W+1)'(ted_pkg::FIFO_DEPTH);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            left_q[wr_ptr_reg]  <= left_res;
            right_q[wr_ptr_reg] <= right_res;
            pos_q[wr_ptr_reg]   <= pos_res;
            rst_q[wr_ptr_reg]   <= restart_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/triggered_envelope_ducker_unit.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    kind, trigger, left_in, right_in,
//                                             entry_index, entry_value
// output    out        out_valid / out_ready  left_out, right_out, curve_position,
//                                             restarted
// config    in         psel/penable/pwrite    paddr, pwdata -> prdata (pready tied high)
//
// one item per cycle while in_ready is high; a sample item's result is valid once it has passed
// memory read, multiply and buffer write, a load item gives no result
// after reset the curve store is swept to full duck, all 4096 entries, one entry a cycle,
// with in_ready low; register writes are taken during the sweep
// a stalled output holds in a 4-entry result buffer; besides the sweep, in_ready drops
// only when buffered items and items already in flight would fill it
module triggered_envelope_ducker_unit #(
    parameter int SAMPLE_BITS = ted_pkg::DEF_SAMPLE_BITS,
    parameter int DELAY_DEPTH = ted_pkg::DEF_DELAY_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic                                trigger,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    input  logic [ted_pkg::CIDX_W-1:0]          entry_index,
    input  logic [ted_pkg::ENTRY_W-1:0]         entry_value,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    output logic [ted_pkg::CIDX_W-1:0]          curve_position,
    output logic                                restarted,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DPTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int DMAX   = DELAY_DEPTH - 1;

    // ---------------- register file ----------------
    logic                               cfg_we;
    logic                               len_we;
    logic [ted_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [ted_pkg::DELAY_CFG_W-1:0]    delay_reg, delay_next;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign len_we = cfg_we && (paddr[2] == ted_pkg::REG_CURVE_LENGTH);

    always_comb
    begin
        len_next   = len_reg;
        delay_next = delay_reg;
        if (cfg_we)
        begin
            unique case (paddr[2])
                ted_pkg::REG_CURVE_LENGTH:  len_next   = pwdata[ted_pkg::LEN_W-1:0];
                ted_pkg::REG_DELAY_SAMPLES: delay_next = pwdata[ted_pkg::DELAY_CFG_W-1:0];
                default:                    len_next   = len_reg;
            endcase
        end
    end

    // read back the raw register value
    always_comb
    begin
        unique case (paddr[2])
            ted_pkg::REG_CURVE_LENGTH:  prdata = 32'(len_reg);
            ted_pkg::REG_DELAY_SAMPLES: prdata = 32'(delay_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- accept stage ----------------
    logic in_acc;
    logic smp_acc;
    logic load_we;
    logic busy;
    logic room;

    // the curve sweep and the result buffer gate new items
    assign in_ready = !busy && room;
    assign in_acc   = in_valid && in_ready;
    assign smp_acc  = in_acc && (kind == ted_pkg::KIND_SAMPLE);
    assign load_we  = in_acc && (kind == ted_pkg::KIND_LOAD);

    // shared delay pointer; the wrap flag tells which slots hold real samples
    logic [DPTR_W-1:0]  ptr_reg, ptr_next;
    logic               wrapped_reg, wrapped_next;
    logic [DPTR_W-1:0]  d_eff;
    logic [DPTR_W-1:0]  rd_addr;
    ted_pkg::lane_ctl_t lane_ctl;

    always_comb
    begin
        // delay clamp to the line length
        d_eff = (32'(delay_reg) > 32'(DMAX)) ? DPTR_W'(DMAX) : DPTR_W'(delay_reg);
        // tap address, modulo the line length
        if (ptr_reg >= d_eff)
            rd_addr = ptr_reg - d_eff;
        else
            rd_addr = DPTR_W'({1'b0, ptr_reg} + (DPTR_W+1)'(DELAY_DEPTH) - {1'b0, d_eff});

        lane_ctl.sample_we = smp_acc;
        lane_ctl.fill_ok   = wrapped_reg || (ptr_reg >= d_eff);
        lane_ctl.bypass    = (d_eff == '0);

        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (smp_acc)
        begin
            if (ptr_reg == DPTR_W'(DMAX))
            begin
                ptr_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    // ---------------- curve store and play position ----------------
    logic [ted_pkg::CIDX_W-1:0]  pos;
    logic [ted_pkg::ENTRY_W-1:0] entry_q;
    logic [ted_pkg::GAIN_W-1:0]  gain;

    ted_curve u_curve (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_we  (load_we),
        .load_idx (entry_index),
        .load_val (entry_value),
        .smp_acc  (smp_acc),
        .trigger  (trigger),
        .len_we   (len_we),
        .len_val  (pwdata[ted_pkg::LEN_W-1:0]),
        .pos      (pos),
        .entry_q  (entry_q),
        .busy     (busy)
    );

    // gain = 1 - curve entry, Q1.16
    assign gain = ted_pkg::FULL_DUCK - entry_q;

    // ---------------- pipeline bookkeeping ----------------
    // stage 1: memory data ready; stage 2: products registered
    logic                        v1_reg, v2_reg;
    logic [ted_pkg::CIDX_W-1:0]  pos1_reg, pos2_reg;
    logic                        trig1_reg, trig2_reg;
    logic [1:0]                  inflight;

    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= ted_pkg::LEN_RESET;
            delay_reg   <= '0;
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            delay_reg   <= delay_next;
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            v1_reg      <= smp_acc;
            v2_reg      <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos1_reg  <= pos;
        trig1_reg <= trigger;
        pos2_reg  <= pos1_reg;
        trig2_reg <= trig1_reg;
    end

    // ---------------- channel lanes ----------------
    logic signed [SAMPLE_BITS-1:0] left_scaled;
    logic signed [SAMPLE_BITS-1:0] right_scaled;

    ted_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_DEPTH (DELAY_DEPTH),
        .DPTR_W      (DPTR_W)
    ) u_lane_left (
        .clk       (clk),
        .ctl       (lane_ctl),
        .wr_addr   (ptr_reg),
        .rd_addr   (rd_addr),
        .sample_in (left_in),
        .gain      (gain),
        .scaled    (left_scaled)
    );

    ted_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_DEPTH (DELAY_DEPTH),
        .DPTR_W      (DPTR_W)
    ) u_lane_right (
        .clk       (clk),
        .ctl       (lane_ctl),
        .wr_addr   (ptr_reg),
        .rd_addr   (rd_addr),
        .sample_in (right_in),
        .gain      (gain),
        .scaled    (right_scaled)
    );

    // ---------------- merge into the result buffer ----------------
    ted_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (v2_reg),
        .left_res       (left_scaled),
        .right_res      (right_scaled),
        .pos_res        (pos2_reg),
        .restart_res    (trig2_reg),
        .inflight       (inflight),
        .room           (room),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .curve_position (curve_position),
        .restarted      (restarted)
    );

endmodule

### hdl/ted_checker.sv
module ted_checker #(
    parameter int SAMPLE_BITS = ted_pkg::DEF_SAMPLE_BITS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             kind,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [SAMPLE_BITS-1:0]           left_out,
    input logic [SAMPLE_BITS-1:0]           right_out,
    input logic [ted_pkg::CIDX_W-1:0]       curve_position,
    input logic                             restarted
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
            && $stable(curve_position) && $stable(restarted))
        else $error("stalled result changed");

    // a restart always plays the first curve entry
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && restarted |-> curve_position == '0)
        else $error("restart not at curve start");

    // curve sweep blocks items right after reset
    a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready && !out_valid)
        else $error("item path open during sweep");

    // an empty buffer fills only from an earlier accepted sample item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && kind == ted_pkg::KIND_SAMPLE, 3))
        else $error("result without matching sample item");

endmodule

bind triggered_envelope_ducker_unit ted_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ted_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_out       (left_out),
    .right_out      (right_out),
    .curve_position (curve_position),
    .restarted      (restarted)
);
